// File: rtl/clnsq_pkg.sv
// Shared types, codes and constants of the character LCD nibble sequencer.
`timescale 1ns / 1ps
package clnsq_pkg;

  // Request codes carried in the input tuser field
  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_INSTR  = 3'd1,
    CMD_CHAR   = 3'd2,
    CMD_CURSOR = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_HOME   = 3'd5,
    CMD_HEX    = 3'd6
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TWO_LINE   = 3'd0,
    REG_LINE1_BASE = 3'd1,
    REG_LINE2_BASE = 3'd2,
    REG_LINE3_BASE = 3'd3,
    REG_LINE4_BASE = 3'd4,
    REG_DISP_FLAGS = 3'd5,
    REG_ENTRY_FLAGS = 3'd6
  } reg_e;

  localparam int unsigned WaitW  = 13;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned CfgW   = 7;

  // Wait times in microseconds
  localparam logic [WaitW-1:0] WAIT_NONE  = 13'd0;
  localparam logic [WaitW-1:0] WAIT_CMD   = 13'd45;
  localparam logic [WaitW-1:0] WAIT_DATA  = 13'd50;
  localparam logic [WaitW-1:0] WAIT_INIT2 = 13'd120;
  localparam logic [WaitW-1:0] WAIT_SLOW  = 13'd2045;
  localparam logic [WaitW-1:0] WAIT_INIT1 = 13'd5000;

  // Instruction bytes
  localparam logic [7:0] INS_FUNC_2LINE = 8'h28;
  localparam logic [7:0] INS_FUNC_1LINE = 8'h20;
  localparam logic [7:0] INS_DISP_CTRL  = 8'h08;
  localparam logic [7:0] INS_CLEAR      = 8'h01;
  localparam logic [7:0] INS_HOME       = 8'h02;
  localparam logic [7:0] INS_ENTRY      = 8'h04;
  localparam logic [7:0] INS_SET_DDRAM  = 8'h80;
  localparam logic [3:0] NIB_WAKE       = 4'h3;
  localparam logic [3:0] NIB_4BIT       = 4'h2;

  // Run lengths in nibbles
  localparam logic [IdxW-1:0] LEN_INIT = 4'd12;
  localparam logic [IdxW-1:0] LEN_BYTE = 4'd2;

  // Configuration reset values
  localparam logic       RST_TWO_LINE    = 1'b1;
  localparam logic [6:0] RST_LINE1_BASE  = 7'd0;
  localparam logic [6:0] RST_LINE2_BASE  = 7'd64;
  localparam logic [6:0] RST_LINE3_BASE  = 7'd20;
  localparam logic [6:0] RST_LINE4_BASE  = 7'd84;
  localparam logic [2:0] RST_DISP_FLAGS  = 3'd4;
  localparam logic [1:0] RST_ENTRY_FLAGS = 2'd2;

  typedef struct packed {
    logic             two_line;
    logic [3:0][6:0]  line_base;
    logic [2:0]       disp_flags;
    logic [1:0]       entry_flags;
  } cfg_t;

  // One latched request, with the clipped digit count and run length
  typedef struct packed {
    cmd_e            cmd;
    logic [7:0]      byte_value;
    logic [6:0]      column;
    logic [1:0]      row;
    logic [15:0]     hex_value;
    logic [2:0]      ndig;
    logic [IdxW-1:0] len;
  } req_t;

  // One nibble write on the LCD bus
  typedef struct packed {
    logic             reg_select;
    logic [3:0]       nibble;
    logic [WaitW-1:0] wait_us;
    logic             last;
  } nib_t;

  // Lower-case ASCII for one hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else begin
      c = 8'h57 + {4'd0, d};
    end
    return c;
  endfunction

endpackage

// File: rtl/clnsq_cfg_regs.sv
// Configuration register bank of the character LCD nibble sequencer.
`timescale 1ns / 1ps
module clnsq_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  clnsq_pkg::reg_e              cfg_addr_i,
  input  logic [clnsq_pkg::CfgW-1:0]   cfg_wdata_i,
  output clnsq_pkg::cfg_t              cfg_o
);

  clnsq_pkg::cfg_t cfg_q;

  // Register writes, one field per index; unused index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.two_line     <= clnsq_pkg::RST_TWO_LINE;
      cfg_q.line_base[0] <= clnsq_pkg::RST_LINE1_BASE;
      cfg_q.line_base[1] <= clnsq_pkg::RST_LINE2_BASE;
      cfg_q.line_base[2] <= clnsq_pkg::RST_LINE3_BASE;
      cfg_q.line_base[3] <= clnsq_pkg::RST_LINE4_BASE;
      cfg_q.disp_flags   <= clnsq_pkg::RST_DISP_FLAGS;
      cfg_q.entry_flags  <= clnsq_pkg::RST_ENTRY_FLAGS;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        clnsq_pkg::REG_TWO_LINE:    cfg_q.two_line     <= cfg_wdata_i[0];
        clnsq_pkg::REG_LINE1_BASE:  cfg_q.line_base[0] <= cfg_wdata_i[6:0];
        clnsq_pkg::REG_LINE2_BASE:  cfg_q.line_base[1] <= cfg_wdata_i[6:0];
        clnsq_pkg::REG_LINE3_BASE:  cfg_q.line_base[2] <= cfg_wdata_i[6:0];
        clnsq_pkg::REG_LINE4_BASE:  cfg_q.line_base[3] <= cfg_wdata_i[6:0];
        clnsq_pkg::REG_DISP_FLAGS:  cfg_q.disp_flags   <= cfg_wdata_i[2:0];
        clnsq_pkg::REG_ENTRY_FLAGS: cfg_q.entry_flags  <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/clnsq_nibble_gen.sv
// Combinational expander: nibble number idx of a latched request.
`timescale 1ns / 1ps
module clnsq_nibble_gen (
  input  clnsq_pkg::req_t              req_i,
  input  clnsq_pkg::cfg_t              cfg_i,
  input  logic [clnsq_pkg::IdxW-1:0]   idx_i,
  output clnsq_pkg::nib_t              nib_o
);

  logic [7:0]                  byte_val;
  logic [clnsq_pkg::WaitW-1:0] low_wait;
  logic                        rs;
  logic [1:0]                  init_j;
  logic [6:0]                  addr;
  logic [1:0]                  dig_sh;
  logic [3:0]                  digit;
  logic [15:0]                 hex_shift;
  logic                        hi_half;

  assign hi_half = ~idx_i[0];
  // Byte slot of init after the four wake-up nibbles
  assign init_j  = 2'(idx_i[3:1] - 3'd2);
  assign addr    = 7'(cfg_i.line_base[req_i.row] + req_i.column);
  // Hex digits go out most significant first
  assign dig_sh    = 2'(req_i.ndig - 3'd1 - {1'b0, idx_i[2:1]});
  assign hex_shift = req_i.hex_value >> {dig_sh, 2'b00};
  assign digit     = hex_shift[3:0];

  // Byte being sent and the wait after its low nibble
  always_comb begin
    byte_val = 8'h00;
    low_wait = clnsq_pkg::WAIT_CMD;
    rs       = 1'b0;
    case (req_i.cmd)
      clnsq_pkg::CMD_INIT: begin
        case (init_j)
          2'd0: byte_val = cfg_i.two_line ? clnsq_pkg::INS_FUNC_2LINE
                                          : clnsq_pkg::INS_FUNC_1LINE;
          2'd1: byte_val = clnsq_pkg::INS_DISP_CTRL | {5'd0, cfg_i.disp_flags};
          2'd2: begin
            byte_val = clnsq_pkg::INS_CLEAR;
            low_wait = clnsq_pkg::WAIT_SLOW;
          end
          default: byte_val = clnsq_pkg::INS_ENTRY | {6'd0, cfg_i.entry_flags};
        endcase
      end
      clnsq_pkg::CMD_INSTR:  byte_val = req_i.byte_value;
      clnsq_pkg::CMD_CHAR: begin
        byte_val = req_i.byte_value;
        low_wait = clnsq_pkg::WAIT_DATA;
        rs       = 1'b1;
      end
      clnsq_pkg::CMD_CURSOR: byte_val = clnsq_pkg::INS_SET_DDRAM | {1'b0, addr};
      clnsq_pkg::CMD_CLEAR: begin
        byte_val = clnsq_pkg::INS_CLEAR;
        low_wait = clnsq_pkg::WAIT_SLOW;
      end
      clnsq_pkg::CMD_HOME: begin
        byte_val = clnsq_pkg::INS_HOME;
        low_wait = clnsq_pkg::WAIT_SLOW;
      end
      clnsq_pkg::CMD_HEX: begin
        byte_val = clnsq_pkg::hex_char(digit);
        low_wait = clnsq_pkg::WAIT_DATA;
        rs       = 1'b1;
      end
      default: ;
    endcase
  end

  // Split into nibbles; init opens with four single wake-up nibbles
  always_comb begin
    nib_o.reg_select = rs;
    nib_o.last       = (idx_i == 4'(req_i.len - 4'd1));
    if (req_i.cmd == clnsq_pkg::CMD_INIT && idx_i < 4'd4) begin
      nib_o.nibble = (idx_i == 4'd3) ? clnsq_pkg::NIB_4BIT : clnsq_pkg::NIB_WAKE;
      nib_o.wait_us = (idx_i == 4'd0) ? clnsq_pkg::WAIT_INIT1 : clnsq_pkg::WAIT_INIT2;
    end else if (hi_half) begin
      nib_o.nibble  = byte_val[7:4];
      nib_o.wait_us = clnsq_pkg::WAIT_NONE;
    end else begin
      nib_o.nibble  = byte_val[3:0];
      nib_o.wait_us = low_wait;
    end
  end

endmodule

// File: rtl/char_lcd_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer (4-bit bus, timed mode).
`timescale 1ns / 1ps
// Usage: a request enters on the s_axis channel (command in tuser, operands
// in tdata) and leaves as a run of nibble writes on the m_axis channel, one
// item per enable pulse: tuser is the register-select level, tdata carries
// the nibble and the wait in microseconds after it, tlast marks the final
// nibble of the run. Init gives 12 nibbles, instruction, character, cursor,
// clear and home give 2, hex gives 2 per digit, an unused code or a hex
// request with no digits gives none.
// A request is first held in the request register; its first nibble then
// enters the output register and appears on m_axis. One nibble leaves per
// cycle while the receiver does not stall; the expander handles one
// request at a time. The next request is taken in the cycle its
// predecessor's last nibble enters the output register, so runs follow
// each other without a gap. A stalled receiver holds the output register
// and the request register; nothing is lost. Reset empties both and loads
// the configuration defaults. The configuration port is a plain write port;
// the user must write it only while idle; the block does not enforce this.
module char_lcd_nibble_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [6:0]  cfg_wdata_i,
  // Request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] byte_value, [14:8] column, [16:15] row, [32:17] hex_value,
  // [36:33] hex_digits, [39:37] zero
  input  logic [39:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]  s_axis_tuser,
  // Nibble write channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] nibble, [16:4] wait_us, [23:17] zero
  output logic [23:0] m_axis_tdata,
  // [0] reg_select
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  clnsq_pkg::cfg_t                cfg;
  clnsq_pkg::req_t                req_d, req_q;
  logic                           req_vld_q;
  logic [clnsq_pkg::IdxW-1:0]     idx_d, idx_q;
  clnsq_pkg::nib_t                nib, out_q;
  logic                           out_vld_q;
  logic                           out_load, req_done, s_take;
  logic [3:0]                     ndig_raw;
  logic [2:0]                     ndig;

  clnsq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (clnsq_pkg::reg_e'(cfg_addr_i)),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Decode an incoming request: clip digit count, work out run length
  assign ndig_raw = s_axis_tdata[36:33];
  assign ndig     = (ndig_raw > 4'd4) ? 3'd4 : ndig_raw[2:0];

  always_comb begin
    req_d.cmd        = clnsq_pkg::cmd_e'(s_axis_tuser);
    req_d.byte_value = s_axis_tdata[7:0];
    req_d.column     = s_axis_tdata[14:8];
    req_d.row        = s_axis_tdata[16:15];
    req_d.hex_value  = s_axis_tdata[32:17];
    req_d.ndig       = ndig;
    case (req_d.cmd)
      clnsq_pkg::CMD_INIT:   req_d.len = clnsq_pkg::LEN_INIT;
      clnsq_pkg::CMD_INSTR,
      clnsq_pkg::CMD_CHAR,
      clnsq_pkg::CMD_CURSOR,
      clnsq_pkg::CMD_CLEAR,
      clnsq_pkg::CMD_HOME:   req_d.len = clnsq_pkg::LEN_BYTE;
      clnsq_pkg::CMD_HEX:    req_d.len = {ndig, 1'b0};
      default:               req_d.len = '0;
    endcase
  end

  clnsq_nibble_gen u_gen (
    .req_i (req_q),
    .cfg_i (cfg),
    .idx_i (idx_q),
    .nib_o (nib)
  );

  // Handshake: load a nibble when the output slot frees; take the next
  // request once the current run is finished
  assign out_load = req_vld_q && (req_q.len != '0) && (!out_vld_q || m_axis_tready);
  assign req_done = req_vld_q && ((req_q.len == '0) || (out_load && nib.last));
  assign s_axis_tready = !req_vld_q || req_done;
  assign s_take   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    idx_d = idx_q;
    if (s_take || req_done) begin
      idx_d = '0;
    end else if (out_load) begin
      idx_d = idx_q + 4'd1;
    end
  end

  // Request register and nibble counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      idx_q <= idx_d;
      if (s_take) begin
        req_vld_q <= 1'b1;
      end else if (req_done) begin
        req_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      req_q <= req_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= nib;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q.wait_us, out_q.nibble};
  assign m_axis_tuser  = out_q.reg_select;
  assign m_axis_tlast  = out_q.last;

endmodule
